// File: rtl/segment_box_overlap_test_core_assert.svh
// ---------------------------------------------------------------------------
// Segment/box overlap core - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_BOX_OVERLAP_TEST_CORE_ASSERT_SVH
`define SEGMENT_BOX_OVERLAP_TEST_CORE_ASSERT_SVH

// same-cycle implication
`define SBOX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBOX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sbox_pkg.sv
// ---------------------------------------------------------------------------
// sbox_pkg
// Widths, types and register codes of the segment/box overlap core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbox_pkg;

    localparam int COORD_WIDTH     = 32;
    // doubled midpoint, box centered: sum of four coordinates
    localparam int MID_WIDTH       = COORD_WIDTH + 2;
    // doubled half vector and doubled half extent
    localparam int DIF_WIDTH       = COORD_WIDTH + 1;
    localparam int FACE_WIDTH      = COORD_WIDTH + 3;
    localparam int PROD_WIDTH      = MID_WIDTH + DIF_WIDTH;
    localparam int CROSS_WIDTH     = PROD_WIDTH + 1;
    localparam int REG_INDEX_WIDTH = 3;
    localparam int AXES            = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [MID_WIDTH-1:0]   mid_t;
    typedef logic signed [DIF_WIDTH-1:0]   dif_t;
    typedef logic        [DIF_WIDTH-1:0]   mag_t;
    typedef logic signed [FACE_WIDTH-1:0]  face_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;

    // index 0 is x, 1 is y, 2 is z
    typedef coord_t [AXES-1:0] vec_t;

    typedef struct packed {
        vec_t low;
        vec_t high;
    } box_t;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_BOX_LOW_X  = 3'd0,
        REG_BOX_LOW_Y  = 3'd1,
        REG_BOX_LOW_Z  = 3'd2,
        REG_BOX_HIGH_X = 3'd3,
        REG_BOX_HIGH_Y = 3'd4,
        REG_BOX_HIGH_Z = 3'd5
    } reg_index_t;

    // front-end result handed to the cross-axis pipeline
    typedef struct packed {
        mid_t [AXES-1:0] m;
        dif_t [AXES-1:0] d;
        dif_t [AXES-1:0] h;
        mag_t [AXES-1:0] mag_d;
        logic            face_sep;
    } prep_t;

    // cross-axis pairs (i,j): (y,z), (x,z), (x,y)
    localparam int PAIR_I [AXES] = '{1, 0, 0};
    localparam int PAIR_J [AXES] = '{2, 2, 1};

endpackage

`default_nettype wire

// File: rtl/sbox_prep.sv
// ---------------------------------------------------------------------------
// sbox_prep
// Stages 1-2: doubled midpoint, half vector and extent, then magnitudes
// and the three box-face axis tests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "segment_box_overlap_test_core_assert.svh"

module sbox_prep
    import sbox_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire box_t  box,
    input  wire logic  up_valid,
    output logic       up_ready,
    input  wire vec_t  seg_start,
    input  wire vec_t  seg_end,
    output logic       dn_valid,
    input  wire logic  dn_ready,
    output prep_t      dn_data
);

    logic             s1_valid_reg;
    mid_t [AXES-1:0]  s1_m_reg, s1_m_next;
    dif_t [AXES-1:0]  s1_d_reg, s1_d_next;
    dif_t [AXES-1:0]  s1_h_reg, s1_h_next;
    logic             s2_valid_reg;
    prep_t            s2_reg, s2_next;
    logic             s1_ready;
    logic             s2_ready;

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            s1_m_next[k] = mid_t'($signed(seg_start[k])) + mid_t'($signed(seg_end[k]))
                         - mid_t'($signed(box.low[k])) - mid_t'($signed(box.high[k]));
            s1_d_next[k] = dif_t'($signed(seg_start[k])) - dif_t'($signed(seg_end[k]));
            s1_h_next[k] = dif_t'($signed(box.high[k])) - dif_t'($signed(box.low[k]));
        end
    end

    always_comb
    begin
        logic [MID_WIDTH-1:0] mag_m;
        face_t                lhs;
        face_t                rhs;
        s2_next          = '0;
        s2_next.m        = s1_m_reg;
        s2_next.d        = s1_d_reg;
        s2_next.h        = s1_h_reg;
        s2_next.face_sep = 1'b0;
        for (int k = 0; k < AXES; k++)
        begin
            mag_m = s1_m_reg[k][MID_WIDTH-1] ? MID_WIDTH'(-$signed(s1_m_reg[k]))
                                             : s1_m_reg[k];
            s2_next.mag_d[k] = s1_d_reg[k][DIF_WIDTH-1] ? DIF_WIDTH'(-$signed(s1_d_reg[k]))
                                                        : s1_d_reg[k];
            lhs = face_t'({1'b0, mag_m});
            rhs = face_t'($signed(s1_h_reg[k])) + face_t'({2'b00, s2_next.mag_d[k]});
            if (lhs > rhs)
            begin
                s2_next.face_sep = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_m_reg <= s1_m_next;
            s1_d_reg <= s1_d_next;
            s1_h_reg <= s1_h_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_reg;

    `SBOX_ASSERT_NXT(a_prep_s1_hold, s1_valid_reg && !s2_ready,
        s1_valid_reg && $stable(s1_m_reg), "stage 1 item lost under stall")
    `SBOX_ASSERT_NXT(a_prep_s2_hold, s2_valid_reg && !dn_ready,
        s2_valid_reg && $stable(s2_reg), "stage 2 item lost under stall")

endmodule

`default_nettype wire

// File: rtl/sbox_cross.sv
// ---------------------------------------------------------------------------
// sbox_cross
// Stages 3-5: cross-axis products, their sums, and the final hit decision
// held in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "segment_box_overlap_test_core_assert.svh"

module sbox_cross
    import sbox_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_ready,
    input  wire prep_t up_data,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic       hit
);

    logic              s3_valid_reg;
    prod_t [AXES-1:0]  s3_mdj_reg, s3_mdj_next;   // m[i]*d[j]
    prod_t [AXES-1:0]  s3_mdi_reg, s3_mdi_next;   // m[j]*d[i]
    prod_t [AXES-1:0]  s3_hdj_reg, s3_hdj_next;   // h[i]*|d[j]|
    prod_t [AXES-1:0]  s3_hdi_reg, s3_hdi_next;   // h[j]*|d[i]|
    logic              s3_face_reg;
    logic              s4_valid_reg;
    cross_t [AXES-1:0] s4_lhs_reg, s4_lhs_next;
    cross_t [AXES-1:0] s4_rhs_reg, s4_rhs_next;
    logic              s4_face_reg;
    logic              s5_valid_reg;
    logic              s5_hit_reg, s5_hit_next;
    logic              s3_ready, s4_ready, s5_ready;

    assign s5_ready = !s5_valid_reg || !out_stall;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign up_ready = s3_ready;

    always_comb
    begin
        for (int p = 0; p < AXES; p++)
        begin
            s3_mdj_next[p] = prod_t'($signed(up_data.m[PAIR_I[p]]))
                           * prod_t'($signed(up_data.d[PAIR_J[p]]));
            s3_mdi_next[p] = prod_t'($signed(up_data.m[PAIR_J[p]]))
                           * prod_t'($signed(up_data.d[PAIR_I[p]]));
            s3_hdj_next[p] = prod_t'($signed(up_data.h[PAIR_I[p]]))
                           * prod_t'($signed({1'b0, up_data.mag_d[PAIR_J[p]]}));
            s3_hdi_next[p] = prod_t'($signed(up_data.h[PAIR_J[p]]))
                           * prod_t'($signed({1'b0, up_data.mag_d[PAIR_I[p]]}));
        end
    end

    always_comb
    begin
        for (int p = 0; p < AXES; p++)
        begin
            s4_lhs_next[p] = cross_t'($signed(s3_mdj_reg[p])) - cross_t'($signed(s3_mdi_reg[p]));
            s4_rhs_next[p] = cross_t'($signed(s3_hdj_reg[p])) + cross_t'($signed(s3_hdi_reg[p]));
        end
    end

    // |lhs| stays below 2^(CROSS_WIDTH-2), so the magnitude is still positive
    always_comb
    begin
        cross_t mag;
        logic   sep;
        sep = s4_face_reg;
        for (int p = 0; p < AXES; p++)
        begin
            mag = s4_lhs_reg[p][CROSS_WIDTH-1] ? cross_t'(-$signed(s4_lhs_reg[p]))
                                               : s4_lhs_reg[p];
            if ($signed(mag) > $signed(s4_rhs_reg[p]))
            begin
                sep = 1'b1;
            end
        end
        s5_hit_next = !sep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= up_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && up_valid)
        begin
            s3_mdj_reg  <= s3_mdj_next;
            s3_mdi_reg  <= s3_mdi_next;
            s3_hdj_reg  <= s3_hdj_next;
            s3_hdi_reg  <= s3_hdi_next;
            s3_face_reg <= up_data.face_sep;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_lhs_reg  <= s4_lhs_next;
            s4_rhs_reg  <= s4_rhs_next;
            s4_face_reg <= s3_face_reg;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_hit_reg <= s5_hit_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign hit       = s5_hit_reg;

    `SBOX_ASSERT_NXT(a_cross_s3_hold, s3_valid_reg && !s4_ready,
        s3_valid_reg && $stable(s3_face_reg), "stage 3 item lost under stall")
    `SBOX_ASSERT_NXT(a_cross_s4_hold, s4_valid_reg && !s5_ready,
        s4_valid_reg && $stable(s4_lhs_reg), "stage 4 item lost under stall")

endmodule

`default_nettype wire

// File: rtl/segment_box_overlap_test_core.sv
// ---------------------------------------------------------------------------
// segment_box_overlap_test_core
// Segment versus axis-aligned box separating axis test, one hit per segment.
// ---------------------------------------------------------------------------
// Takes one segment per clock unless in_stall is high. Two front-end stages
// for the face axes, then products, sums and the final compare make the hit
// flag; the stage-3 bank of twelve exact products sets the cycle time.
// Items move through a valid/stall pipeline, so bubbles collapse; while a
// finished result waits on out_stall, new segments enter until it fills.
// The box corners are six signed Q16.16 registers written through the cfg
// port (0..2 low x/y/z, 3..5 high x/y/z, others ignored); write them only
// while no segment is in flight. All arithmetic is exact.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_box_overlap_test_core_assert.svh"

module segment_box_overlap_test_core
    import sbox_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [REG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]     cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire coord_t                     start_x,
    input  wire coord_t                     start_y,
    input  wire coord_t                     start_z,
    input  wire coord_t                     end_x,
    input  wire coord_t                     end_y,
    input  wire coord_t                     end_z,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            hit
);

    box_t  box_reg, box_next;
    vec_t  seg_start, seg_end;
    logic  in_ready;
    logic  prep_valid, prep_ready;
    prep_t prep_data;

    always_comb
    begin
        box_next = box_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BOX_LOW_X:  box_next.low[0]  = cfg_data;
                REG_BOX_LOW_Y:  box_next.low[1]  = cfg_data;
                REG_BOX_LOW_Z:  box_next.low[2]  = cfg_data;
                REG_BOX_HIGH_X: box_next.high[0] = cfg_data;
                REG_BOX_HIGH_Y: box_next.high[1] = cfg_data;
                REG_BOX_HIGH_Z: box_next.high[2] = cfg_data;
                default:        box_next = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else
        begin
            box_reg <= box_next;
        end
    end

    assign seg_start = {start_z, start_y, start_x};
    assign seg_end   = {end_z, end_y, end_x};
    assign in_stall  = !in_ready;

    sbox_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .box       (box_reg),
        .up_valid  (in_valid),
        .up_ready  (in_ready),
        .seg_start (seg_start),
        .seg_end   (seg_end),
        .dn_valid  (prep_valid),
        .dn_ready  (prep_ready),
        .dn_data   (prep_data)
    );

    sbox_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (prep_valid),
        .up_ready  (prep_ready),
        .up_data   (prep_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit)
    );

    // an empty output register lets the whole pipeline advance
    `SBOX_ASSERT_IMP(a_top_empty_takes, !out_valid, !in_stall,
        "input stalled with empty output register")

endmodule

`default_nettype wire

// File: tb/sv/tb_segment_box_overlap_test_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_segment_box_overlap_test_core
// Self-checking bench for the segment versus box separating axis core.
// Segments are streamed in bursts against a series of box settings (reset
// box, unit box, full-range box, inverted and degenerate boxes, random
// boxes). Each accepted segment gets its hit flag worked out by an exact
// 128-bit separating axis computation and queued; every returned hit is
// compared with the oldest queued one. The result side stalls in random
// runs and twice holds off long enough to back the pipeline up.
// ---------------------------------------------------------------------------
module tb_segment_box_overlap_test_core
    import sbox_pkg::*;
();

    localparam int     CLK_HALF     = 2;
    localparam int     RESET_CYCLES = 5;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     PHASES       = 9;
    localparam int     PHASE_ITEMS  = 80;
    localparam coord_t ONE          = 32'sh0001_0000;
    localparam coord_t HALF         = 32'sh0000_8000;
    localparam coord_t COORD_MIN    = 32'sh8000_0000;
    localparam coord_t COORD_MAX    = 32'sh7fff_ffff;
    // indexes past the box registers; writes there must be ignored
    localparam logic [REG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [127:0] exact_t;

    typedef struct {
        coord_t start[3];
        coord_t stop[3];
    } segment_t;

    typedef struct {
        coord_t low[3];
        coord_t high[3];
    } box_corners_t;

    typedef struct {
        int unsigned tag;
        logic        hit;
        segment_t    seg;
    } hit_expect_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [REG_INDEX_WIDTH-1:0] cfg_index;
    logic [COORD_WIDTH-1:0]     cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    coord_t                     start_x;
    coord_t                     start_y;
    coord_t                     start_z;
    coord_t                     end_x;
    coord_t                     end_y;
    coord_t                     end_z;
    logic                       out_valid;
    logic                       out_stall;
    logic                       hit;

    box_corners_t box_model;
    hit_expect_t  pending_hits[$];
    hit_expect_t  head_hit;
    int unsigned  sent_count;
    int unsigned  mismatches;
    int           stall_pct;
    int           holdoff_left;
    int           run_left;
    logic         run_stalled;

    segment_box_overlap_test_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Exact hit prediction
    // ------------------------------------------------------------------
    function automatic exact_t mag(input exact_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic predict_hit(input segment_t seg);
        exact_t m[3];
        exact_t d[3];
        exact_t h[3];
        exact_t lhs;
        exact_t rhs;
        int     k;
        int     i;
        int     j;
        logic   sep;
        sep = 1'b0;
        // all terms doubled: midpoint offset, half vector, half extent
        for (k = 0; k < 3; k++)
        begin
            m[k] = exact_t'(seg.start[k]) + exact_t'(seg.stop[k])
                 - exact_t'(box_model.low[k]) - exact_t'(box_model.high[k]);
            d[k] = exact_t'(seg.start[k]) - exact_t'(seg.stop[k]);
            h[k] = exact_t'(box_model.high[k]) - exact_t'(box_model.low[k]);
            if (mag(m[k]) > h[k] + mag(d[k]))
                sep = 1'b1;
        end
        // cross axes: (y,z), (x,z), (x,y)
        for (k = 0; k < 3; k++)
        begin
            i   = (k == 0) ? 1 : 0;
            j   = (k == 2) ? 1 : 2;
            lhs = mag(m[i] * d[j] - m[j] * d[i]);
            rhs = h[i] * mag(d[j]) + h[j] * mag(d[i]);
            if (lhs > rhs)
                sep = 1'b1;
        end
        return !sep;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic segment_t seg_of(input coord_t sx, input coord_t sy, input coord_t sz,
                                        input coord_t ex, input coord_t ey, input coord_t ez);
        segment_t s;
        s.start[0] = sx;
        s.start[1] = sy;
        s.start[2] = sz;
        s.stop[0]  = ex;
        s.stop[1]  = ey;
        s.stop[2]  = ez;
        return s;
    endfunction

    function automatic box_corners_t cube_box(input coord_t lo, input coord_t hi);
        box_corners_t b;
        int           k;
        for (k = 0; k < 3; k++)
        begin
            b.low[k]  = lo;
            b.high[k] = hi;
        end
        return b;
    endfunction

    // point in or around the span of a and b, up to half a span beyond each side
    function automatic coord_t near_span(input coord_t a, input coord_t b);
        longint          lo_v;
        longint          hi_v;
        longint          w;
        longint unsigned r;
        longint unsigned span;
        longint unsigned off;
        lo_v = a;
        hi_v = b;
        if (lo_v > hi_v)
        begin
            lo_v = b;
            hi_v = a;
        end
        w    = hi_v - lo_v + 1;
        span = 2 * w;
        r    = {$urandom(), $urandom()};
        off  = r % span;
        return coord_t'(lo_v - w / 2 + longint'(off));
    endfunction

    function automatic coord_t edge_value(input coord_t lo, input coord_t hi);
        case ($urandom_range(6))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return lo;
            4:       return hi;
            5:       return lo - 1;
            default: return hi + 1;
        endcase
    endfunction

    // mostly segments around the current box, some edge values, some raw bits
    function automatic segment_t gen_segment();
        segment_t s;
        int       r;
        int       k;
        r = $urandom_range(99);
        for (k = 0; k < 3; k++)
        begin
            if (r < 15)
            begin
                s.start[k] = $urandom();
                s.stop[k]  = $urandom();
            end
            else if (r < 25)
            begin
                s.start[k] = edge_value(box_model.low[k], box_model.high[k]);
                s.stop[k]  = edge_value(box_model.low[k], box_model.high[k]);
            end
            else
            begin
                s.start[k] = near_span(box_model.low[k], box_model.high[k]);
                s.stop[k]  = (r < 35) ? s.start[k]
                                      : near_span(box_model.low[k], box_model.high[k]);
            end
        end
        return s;
    endfunction

    // kinds: moderate, degenerate, full range, inverted, raw random corners
    function automatic box_corners_t make_box(input int kind);
        box_corners_t b;
        longint       c;
        longint       w;
        int           k;
        for (k = 0; k < 3; k++)
        begin
            c = longint'($signed($urandom())) >>> 3;
            w = $urandom_range(1, 1 << 24);
            case (kind)
                0:
                begin
                    b.low[k]  = coord_t'(c - w);
                    b.high[k] = coord_t'(c + w);
                end
                1:
                begin
                    b.low[k]  = coord_t'(c);
                    b.high[k] = coord_t'(c);
                end
                2:
                begin
                    b.low[k]  = COORD_MIN;
                    b.high[k] = COORD_MAX;
                end
                3:
                begin
                    b.low[k]  = coord_t'(c + w);
                    b.high[k] = coord_t'(c - w);
                end
                default:
                begin
                    b.low[k]  = $urandom();
                    b.high[k] = $urandom();
                end
            endcase
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Driving, register writes and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("ERROR: %s", what);
    endtask

    task automatic write_box_reg(input logic [REG_INDEX_WIDTH-1:0] idx, input coord_t value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_BOX_LOW_X:  box_model.low[0]  = value;
            REG_BOX_LOW_Y:  box_model.low[1]  = value;
            REG_BOX_LOW_Z:  box_model.low[2]  = value;
            REG_BOX_HIGH_X: box_model.high[0] = value;
            REG_BOX_HIGH_Y: box_model.high[1] = value;
            REG_BOX_HIGH_Z: box_model.high[2] = value;
            default:        ;
        endcase
    endtask

    task automatic set_box(input box_corners_t b);
        write_box_reg(REG_BOX_LOW_X,  b.low[0]);
        write_box_reg(REG_BOX_LOW_Y,  b.low[1]);
        write_box_reg(REG_BOX_LOW_Z,  b.low[2]);
        write_box_reg(REG_BOX_HIGH_X, b.high[0]);
        write_box_reg(REG_BOX_HIGH_Y, b.high[1]);
        write_box_reg(REG_BOX_HIGH_Z, b.high[2]);
    endtask

    // valid stays high after the transfer; the next send or a pause decides
    task automatic send_segment(input segment_t seg);
        hit_expect_t item;
        @(negedge clk);
        in_valid <= 1'b1;
        start_x  <= seg.start[0];
        start_y  <= seg.start[1];
        start_z  <= seg.start[2];
        end_x    <= seg.stop[0];
        end_y    <= seg.stop[1];
        end_z    <= seg.stop[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        item.tag = sent_count;
        item.hit = predict_hit(seg);
        item.seg = seg;
        pending_hits = {pending_hits, item};
        sent_count++;
    endtask

    task automatic pause_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic drain_hits();
        pause_input(1);
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic send_stream(input int count, input int gap_pct);
        int n;
        int burst_left;
        burst_left = 0;
        for (n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(99) < gap_pct)
                    pause_input($urandom_range(1, 10));
                burst_left = $urandom_range(1, 16);
            end
            send_segment(gen_segment());
            burst_left--;
        end
    endtask

    // result side: runs of stall / no stall, plus an optional long hold-off
    initial
    begin
        out_stall <= 1'b0;
        run_left = 0;
        run_stalled = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_left > 0)
            begin
                out_stall <= 1'b1;
                holdoff_left--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_stalled = ($urandom_range(99) < stall_pct);
                    run_left    = $urandom_range(1, 7);
                end
                out_stall <= run_stalled;
                run_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
                report_mismatch($sformatf("hit=%b returned with no segment pending", hit));
            else
            begin
                head_hit = pending_hits.pop_front();
                if (hit !== head_hit.hit)
                    report_mismatch($sformatf(
                        "segment %0d (%h,%h,%h)->(%h,%h,%h): hit=%b expected %b",
                        head_hit.tag, head_hit.seg.start[0], head_hit.seg.start[1],
                        head_hit.seg.start[2], head_hit.seg.stop[0], head_hit.seg.stop[1],
                        head_hit.seg.stop[2], hit, head_hit.hit));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_box();
        // box is a single point at the origin out of reset
        send_segment(seg_of(0, 0, 0, 0, 0, 0));
        send_segment(seg_of(ONE, 0, 0, ONE, 0, 0));
        send_segment(seg_of(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        drain_hits();
    endtask

    task automatic test_unit_box_faces();
        set_box(cube_box(-ONE, ONE));
        send_segment(seg_of(0, 0, 0, 0, 0, 0));
        send_segment(seg_of(ONE, 0, 0, ONE, 0, 0));            // on the face: closed box
        send_segment(seg_of(ONE + 1, 0, 0, ONE + 1, 0, 0));    // one LSB outside
        send_segment(seg_of(-3 * ONE, 0, 0, 3 * ONE, 0, 0));
        send_segment(seg_of(2 * ONE, 0, 0, 3 * ONE, 0, 0));    // face axis separates
        send_segment(seg_of(ONE, ONE, ONE, 5 * ONE, 5 * ONE, 5 * ONE));
        // projections overlap but the line misses a box edge: one per cross axis
        send_segment(seg_of(5 * HALF, 0, 0, 0, 5 * HALF, 0));
        send_segment(seg_of(0, 5 * HALF, 0, 0, 0, 5 * HALF));
        send_segment(seg_of(5 * HALF, 0, 0, 0, 0, 5 * HALF));
        send_segment(seg_of(2 * ONE, 0, 0, 0, 2 * ONE, 0));    // grazes an edge
        send_segment(seg_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_segment(seg_of(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        drain_hits();
    endtask

    task automatic test_full_range_box();
        set_box(cube_box(COORD_MIN, COORD_MAX));
        send_segment(seg_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_segment(seg_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_segment(seg_of(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));
        drain_hits();
    endtask

    task automatic test_inverted_box();
        // negative extents are used as they are, no swap
        set_box(cube_box(ONE, -ONE));
        send_segment(seg_of(0, 0, 0, 0, 0, 0));
        send_segment(seg_of(-3 * ONE, 0, 0, 3 * ONE, 0, 0));
        drain_hits();
    endtask

    task automatic test_unknown_register();
        set_box(cube_box(-ONE, ONE));
        write_box_reg(REG_SPARE_LO, $urandom());
        write_box_reg(REG_SPARE_HI, $urandom());
        send_segment(seg_of(0, 0, 0, 0, 0, 0));
        send_segment(seg_of(ONE, ONE, -ONE, ONE, ONE, -ONE));
        drain_hits();
    endtask

    task automatic test_random_boxes();
        int phase;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 3)
                0:       stall_pct = 0;
                1:       stall_pct = 30;
                default: stall_pct = 60;
            endcase
            set_box(make_box(phase % 5));
            send_stream(PHASE_ITEMS, (phase % 2 == 0) ? 0 : 35);
            drain_hits();
        end
    endtask

    task automatic test_backpressure();
        stall_pct = 0;
        set_box(make_box(0));
        @(posedge clk);
        holdoff_left = 80;
        send_stream(50, 0);
        drain_hits();
        stall_pct = 50;
        holdoff_left = 40;
        send_stream(50, 40);
        drain_hits();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        start_x      <= '0;
        start_y      <= '0;
        start_z      <= '0;
        end_x        <= '0;
        end_y        <= '0;
        end_z        <= '0;
        box_model    = cube_box(0, 0);
        sent_count   = 0;
        mismatches   = 0;
        stall_pct    = 25;
        holdoff_left = 0;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        test_reset_box();
        test_unit_box_faces();
        test_full_range_box();
        test_inverted_box();
        test_unknown_register();
        test_random_boxes();
        test_backpressure();

        drain_hits();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: segment_box_overlap_test_core.f
+incdir+rtl
rtl/sbox_pkg.sv
rtl/sbox_prep.sv
rtl/sbox_cross.sv
rtl/segment_box_overlap_test_core.sv
tb/sv/tb_segment_box_overlap_test_core.sv
